/* rtl/core/jerk_limited_jog_profile_core_assert.svh */
// Assertion macros shared by the jog profile RTL.
`ifndef JERK_LIMITED_JOG_PROFILE_CORE_ASSERT_SVH
`define JERK_LIMITED_JOG_PROFILE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JLJP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("jljp: same-cycle check failed");
`define JLJP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jljp: next-cycle check failed");
`else
`define JLJP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define JLJP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/jljp_pkg.sv */
// Shared types, constants and fixed-point helpers of the jog profile core.
`timescale 1ns / 1ps
package jljp_pkg;

  localparam int FRAC_BITS = 32;
  localparam int HALF_W    = 32;
  localparam int ITER_CNT  = 64;
  localparam int CNT_W     = $clog2(ITER_CNT);
  localparam int MUL_STEPS = 4;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_JOG  = 2'd1,
    FN_STOP = 2'd2,
    FN_LOAD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_JERK_LIMIT  = 2'd1,
    CFG_ACCEL_LIMIT = 2'd2,
    CFG_VEL_LIMIT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PLAN_IDLE = 2'd0,
    PLAN_JOG  = 2'd1,
    PLAN_STOP = 2'd2
  } plan_t;

  typedef enum logic [1:0] {
    RG_UP   = 2'd0,
    RG_HOLD = 2'd1,
    RG_DOWN = 2'd2,
    RG_END  = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    AR_MUL  = 2'd0,
    AR_DIV  = 2'd1,
    AR_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_JSTEP,
    ST_STOP_T0,
    ST_PT_T1,
    ST_PT_KMUL,
    ST_PT_KDIV,
    ST_PT_SEL,
    ST_PT_Q,
    ST_PT_SQRT,
    ST_PT_T2,
    ST_ADV,
    ST_CHECK,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_CMP,
    ST_ACC,
    ST_VMUL,
    ST_VADD,
    ST_PMUL,
    ST_PADD,
    ST_OUT
  } state_t;

  // Product divided by one in Q format, saturating when the quotient overflows.
  function automatic logic [63:0] q_scale(input logic [127:0] p);
    if (p[127:64+FRAC_BITS] != '0) begin
      return '1;
    end
    return p[63+FRAC_BITS:FRAC_BITS];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] neg;
    neg = 64'(-x);
    return x[63] ? neg : 64'(x);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] p, input logic neg);
    logic [63:0] n;
    n = 64'(0 - p);
    if (neg) begin
      return p[63] ? $signed(S64_MIN) : $signed(n);
    end
    return p[63] ? $signed(S64_MAX) : $signed(p);
  endfunction

  function automatic logic signed [63:0] sadd_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? $signed(S64_MIN) : $signed(S64_MAX);
    end
    return s;
  endfunction

  function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

/* rtl/core/jljp_arith.sv */
// Shared multi-cycle multiply, divide and square root unit.
`timescale 1ns / 1ps
`include "jerk_limited_jog_profile_core_assert.svh"
module jljp_arith import jljp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  arith_req_t   req,
  input  logic [63:0]  x_hi,
  input  logic [63:0]  x_lo,
  input  logic [63:0]  y,
  output logic         done,
  output logic [127:0] res
);

  logic             busy_r;
  logic             done_r;
  arith_op_t        op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      a_r;
  logic [63:0]      b_r;
  logic [63:0]      pp_r;
  logic [1:0]       pp_sh_r;
  logic [127:0]     acc_r;
  logic [127:0]     sh_r;
  logic [66:0]      rem_r;

  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;
  logic [127:0]      pp_ext;
  logic [63:0]       div_r;
  logic              div_q;
  logic [66:0]       sq_rem;
  logic [66:0]       sq_trial;
  logic              sq_ge;

  always_comb begin
    a_half = cnt_r[1] ? a_r[63:HALF_W] : a_r[HALF_W-1:0];
    b_half = cnt_r[0] ? b_r[63:HALF_W] : b_r[HALF_W-1:0];
    case (pp_sh_r)
      2'd0:    pp_ext = {64'b0, pp_r};
      2'd1:    pp_ext = {32'b0, pp_r, 32'b0};
      default: pp_ext = {pp_r, 64'b0};
    endcase
    // Restoring division step; the bit shifted out of the remainder forces a subtract.
    div_r    = {rem_r[62:0], sh_r[63]};
    div_q    = rem_r[63] || (div_r >= b_r);
    // Digit-by-digit square root step, two radicand bits at a time.
    sq_rem   = {rem_r[64:0], sh_r[127:126]};
    sq_trial = {1'b0, acc_r[63:0], 2'b01};
    sq_ge    = (sq_rem >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= AR_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r  <= req.op;
        cnt_r <= '0;
        unique case (req.op)
          AR_MUL: begin
            a_r    <= x_lo;
            b_r    <= y;
            acc_r  <= '0;
            busy_r <= 1'b1;
          end
          AR_DIV: begin
            b_r <= y;
            if (y == '0 || x_hi >= y) begin
              sh_r   <= '1;
              done_r <= 1'b1;
            end else begin
              rem_r  <= {3'b0, x_hi};
              sh_r   <= {64'b0, x_lo};
              busy_r <= 1'b1;
            end
          end
          AR_SQRT: begin
            sh_r   <= {x_hi, x_lo};
            rem_r  <= '0;
            acc_r  <= '0;
            busy_r <= 1'b1;
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        unique case (op_r)
          AR_MUL: begin
            if (cnt_r < CNT_W'(MUL_STEPS)) begin
              pp_r    <= a_half * b_half;
              pp_sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
            end
            if (cnt_r != '0) begin
              acc_r <= acc_r + pp_ext;
            end
            if (cnt_r == CNT_W'(MUL_STEPS)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          AR_DIV: begin
            rem_r <= {3'b0, div_q ? 64'(div_r - b_r) : div_r};
            sh_r  <= {sh_r[126:0], div_q};
            if (cnt_r == CNT_W'(ITER_CNT - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            rem_r        <= sq_ge ? 67'(sq_rem - sq_trial) : sq_rem;
            acc_r[63:0]  <= {acc_r[62:0], sq_ge};
            sh_r         <= {sh_r[125:0], 2'b00};
            if (cnt_r == CNT_W'(ITER_CNT - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    case (op_r)
      AR_MUL:  res = acc_r;
      AR_DIV:  res = {64'b0, sh_r[63:0]};
      default: res = {64'b0, acc_r[63:0]};
    endcase
  end

  assign done = done_r;

  `JLJP_ASSERT_NOW(a_done_not_busy, clk, rst_n, done_r, !busy_r)
  `JLJP_ASSERT_NOW(a_start_when_free, clk, rst_n, req.start, !busy_r && !done_r)
  `JLJP_ASSERT_NEXT(a_mul_goes_busy, clk, rst_n, req.start && req.op == AR_MUL, busy_r)

endmodule

/* rtl/core/jerk_limited_jog_profile_core.sv */
// Jerk-limited jog setpoint generator: sequencer, state and configuration.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  in      | in  | in_valid/in_stall | func, direction, start_velocity/accel, load_pos
//  out     | out | out_valid/out_stall | position_out, velocity_out, accel_out
//  cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// A jog or stop start adds work from the 64-step divide and square root
// iterations of the shared arithmetic unit.
// Reset is synchronous; it restores the configuration defaults and clears the state.
// While a word waits on out_stall the input stays stalled.
`timescale 1ns / 1ps
`include "jerk_limited_jog_profile_core_assert.svh"
module jerk_limited_jog_profile_core import jljp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [1:0]  in_direction,
  input  logic signed [63:0] in_start_velocity,
  input  logic signed [63:0] in_start_accel,
  input  logic signed [63:0] in_load_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_position_out,
  output logic signed [63:0] out_velocity_out,
  output logic signed [63:0] out_accel_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  state_t state_r, state_nxt;
  logic   issued_r;

  logic [31:0] tick_period_r;
  logic [47:0] jerk_limit_r;
  logic [47:0] accel_limit_r;
  logic [47:0] velocity_limit_r;

  logic signed [63:0] position_r;
  logic signed [63:0] velocity_r;
  logic signed [63:0] accel_r;
  logic [63:0]        elapsed_r;
  // The last ramp always equals the first, so one register serves both.
  logic [63:0]        pd0_r, pd1_r, pd2_r;
  plan_t              plan_r;
  logic               pending_r;
  logic               stop_sign_r;

  func_t              func_r;
  logic [1:0]         dir_r;
  logic signed [63:0] v0_r;
  logic signed [63:0] a0_r;
  logic [47:0]        jstep_r;
  logic [63:0]        pv_r;
  logic [63:0]        t1_r;
  logic [63:0]        knee_r;
  logic               pt_ret_r;
  logic [63:0]        b1_r, b2_r, b3_r;
  region_t            region_r;
  logic signed [63:0] dd_r;

  arith_req_t   a_req;
  logic [63:0]  a_x_hi, a_x_lo, a_y;
  logic         a_done;
  logic [127:0] a_res;
  logic         op_state;

  logic [63:0] dt64, jerk64, accel64, diff64, b3m;
  logic [63:0] mag_a0, mag_v0;
  logic [63:0] scaled;
  logic        step_neg, step_zero;
  logic signed [63:0] delta;

  jljp_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (a_req),
    .x_hi  (a_x_hi),
    .x_lo  (a_x_lo),
    .y     (a_y),
    .done  (a_done),
    .res   (a_res)
  );

  assign dt64    = {32'b0, tick_period_r};
  assign jerk64  = {16'b0, jerk_limit_r};
  assign accel64 = {16'b0, accel_limit_r};
  assign diff64  = pv_r - knee_r;
  assign b3m     = b3_r - dt64;
  assign mag_a0  = mag64(a0_r);
  assign mag_v0  = mag64(v0_r);
  assign scaled  = q_scale(a_res);

  always_comb begin
    if (plan_r == PLAN_JOG) begin
      step_zero = (dir_r == 2'd0);
      step_neg  = dir_r[1];
    end else begin
      step_zero = 1'b0;
      step_neg  = !stop_sign_r;
    end
    if (region_r == RG_DOWN) begin
      step_neg = !step_neg;
    end
    if (step_zero) begin
      delta = '0;
    end else if (step_neg) begin
      delta = $signed(64'(0 - {16'b0, jstep_r}));
    end else begin
      delta = $signed({16'b0, jstep_r});
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FN_LOAD) ? ST_OUT : ST_JSTEP;
        end
      end
      ST_JSTEP: begin
        if (a_done) begin
          unique case (func_r)
            FN_JOG:  state_nxt = ST_PT_T1;
            FN_STOP: state_nxt = (a0_r == '0) ? ST_PT_T1 : ST_STOP_T0;
            default: state_nxt = ST_ADV;
          endcase
        end
      end
      ST_STOP_T0: if (a_done) state_nxt = ST_ADV;
      ST_PT_T1:   if (a_done) state_nxt = ST_PT_KMUL;
      ST_PT_KMUL: if (a_done) state_nxt = ST_PT_KDIV;
      ST_PT_KDIV: if (a_done) state_nxt = ST_PT_SEL;
      ST_PT_SEL:  state_nxt = (pv_r < knee_r) ? ST_PT_Q : ST_PT_T2;
      ST_PT_Q:    if (a_done) state_nxt = ST_PT_SQRT;
      ST_PT_SQRT, ST_PT_T2: begin
        if (a_done) begin
          state_nxt = pt_ret_r ? ST_B1 : ST_ADV;
        end
      end
      ST_ADV: state_nxt = (plan_r == PLAN_IDLE) ? ST_OUT : ST_CHECK;
      ST_CHECK: begin
        if (plan_r == PLAN_STOP && pending_r && elapsed_r > pd0_r) begin
          state_nxt = ST_PT_T1;
        end else begin
          state_nxt = ST_B1;
        end
      end
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B3;
      ST_B3:   state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_VMUL;
      ST_VMUL: if (a_done) state_nxt = ST_VADD;
      ST_VADD: state_nxt = ST_PMUL;
      ST_PMUL: if (a_done) state_nxt = ST_PADD;
      ST_PADD: state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and arithmetic operand selection.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    op_state  = 1'b1;
    a_req.op  = AR_DIV;
    a_x_hi    = '0;
    a_x_lo    = '0;
    a_y       = jerk64;
    unique case (state_r)
      ST_JSTEP: begin
        a_req.op = AR_MUL;
        a_x_lo   = jerk64;
        a_y      = dt64;
      end
      ST_STOP_T0: begin
        a_x_hi = mag_a0 >> (64 - FRAC_BITS);
        a_x_lo = mag_a0 << FRAC_BITS;
      end
      ST_PT_T1: begin
        a_x_hi = accel64 >> (64 - FRAC_BITS);
        a_x_lo = accel64 << FRAC_BITS;
      end
      ST_PT_KMUL: begin
        a_req.op = AR_MUL;
        a_x_lo   = accel64;
        a_y      = accel64;
      end
      ST_PT_KDIV: begin
        a_x_hi = a_res[127:64];
        a_x_lo = a_res[63:0];
      end
      ST_PT_Q: begin
        a_x_hi = pv_r >> (64 - FRAC_BITS);
        a_x_lo = pv_r << FRAC_BITS;
      end
      ST_PT_SQRT: begin
        a_req.op = AR_SQRT;
        a_x_hi   = a_res[63:0] >> (64 - FRAC_BITS);
        a_x_lo   = a_res[63:0] << FRAC_BITS;
      end
      ST_PT_T2: begin
        a_x_hi = diff64 >> (64 - FRAC_BITS);
        a_x_lo = diff64 << FRAC_BITS;
        a_y    = accel64;
      end
      ST_VMUL: begin
        a_req.op = AR_MUL;
        a_x_lo   = mag64(accel_r);
        a_y      = dt64;
      end
      ST_PMUL: begin
        a_req.op = AR_MUL;
        a_x_lo   = mag64(velocity_r);
        a_y      = dt64;
      end
      default: op_state = 1'b0;
    endcase
    a_req.start = op_state && !issued_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      issued_r         <= 1'b0;
      tick_period_r    <= 32'd4294967;
      jerk_limit_r     <= 48'h1_0000_0000;
      accel_limit_r    <= 48'h1_0000_0000;
      velocity_limit_r <= 48'h1_0000_0000;
      position_r       <= '0;
      velocity_r       <= '0;
      accel_r          <= '0;
      elapsed_r        <= '0;
      pd0_r            <= '0;
      pd1_r            <= '0;
      pd2_r            <= '0;
      plan_r           <= PLAN_IDLE;
      pending_r        <= 1'b0;
      stop_sign_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (a_req.start) begin
        issued_r <= 1'b1;
      end else if (a_done) begin
        issued_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TICK_PERIOD: tick_period_r    <= cfg_data[31:0];
          CFG_JERK_LIMIT:  jerk_limit_r     <= cfg_data;
          CFG_ACCEL_LIMIT: accel_limit_r    <= cfg_data;
          CFG_VEL_LIMIT:   velocity_limit_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            func_r <= func_t'(in_func);
            dir_r  <= in_direction;
            v0_r   <= in_start_velocity;
            a0_r   <= in_start_accel;
            if (in_func == FN_LOAD) begin
              position_r <= in_load_position;
              velocity_r <= in_start_velocity;
              accel_r    <= in_start_accel;
              plan_r     <= PLAN_IDLE;
              pending_r  <= 1'b0;
            end
          end
        end
        ST_JSTEP: begin
          if (a_done) begin
            jstep_r  <= scaled[47:0];
            pt_ret_r <= 1'b0;
            if (func_r == FN_JOG) begin
              elapsed_r <= '0;
              pd0_r     <= '0;
              pv_r      <= {16'b0, velocity_limit_r};
              plan_r    <= PLAN_JOG;
            end else if (func_r == FN_STOP) begin
              elapsed_r   <= '0;
              stop_sign_r <= !(velocity_r > 0);
              plan_r      <= PLAN_STOP;
              if (a0_r == '0) begin
                pd0_r     <= '0;
                pv_r      <= mag_v0;
                pending_r <= 1'b0;
              end
            end
          end
        end
        ST_STOP_T0: begin
          if (a_done) begin
            pd0_r     <= a_res[63:0];
            pd1_r     <= '0;
            pd2_r     <= '0;
            pending_r <= 1'b1;
          end
        end
        ST_PT_T1:   if (a_done) t1_r <= a_res[63:0];
        ST_PT_KDIV: if (a_done) knee_r <= a_res[63:0];
        ST_PT_SQRT: begin
          if (a_done) begin
            pd1_r <= a_res[63:0];
            pd2_r <= '0;
          end
        end
        ST_PT_T2: begin
          if (a_done) begin
            pd1_r <= t1_r;
            pd2_r <= a_res[63:0];
          end
        end
        ST_ADV: begin
          if (plan_r != PLAN_IDLE) begin
            elapsed_r <= uadd_sat(elapsed_r, dt64);
          end
        end
        ST_CHECK: begin
          if (plan_r == PLAN_STOP && pending_r && elapsed_r > pd0_r) begin
            pending_r <= 1'b0;
            pv_r      <= mag64(velocity_r);
            pt_ret_r  <= 1'b1;
          end
        end
        ST_B1: b1_r <= uadd_sat(pd0_r, pd1_r);
        ST_B2: b2_r <= uadd_sat(b1_r, pd2_r);
        ST_B3: b3_r <= uadd_sat(b2_r, pd1_r);
        ST_CMP: begin
          if (elapsed_r <= b1_r) begin
            region_r <= RG_UP;
          end else if (elapsed_r <= b2_r) begin
            region_r <= RG_HOLD;
          end else if (b3_r >= dt64 && elapsed_r <= b3m) begin
            region_r <= RG_DOWN;
          end else begin
            region_r <= RG_END;
          end
        end
        ST_ACC: begin
          unique case (region_r)
            RG_UP, RG_DOWN: accel_r <= sadd_sat(accel_r, delta);
            RG_HOLD: ;
            default: begin
              accel_r <= '0;
              if (plan_r == PLAN_STOP) begin
                velocity_r <= '0;
              end
            end
          endcase
        end
        ST_VMUL: if (a_done) dd_r <= from_mag(scaled, accel_r[63]);
        ST_VADD: velocity_r <= sadd_sat(velocity_r, dd_r);
        ST_PMUL: if (a_done) dd_r <= from_mag(scaled, velocity_r[63]);
        ST_PADD: position_r <= sadd_sat(position_r, dd_r);
        default: ;
      endcase
    end
  end

  assign out_position_out = position_r;
  assign out_velocity_out = velocity_r;
  assign out_accel_out    = accel_r;

  `JLJP_ASSERT_NOW(a_out_blocks_in, clk, rst_n, out_valid, in_stall)
  `JLJP_ASSERT_NOW(a_done_was_issued, clk, rst_n, a_done, issued_r)
  `JLJP_ASSERT_NOW(a_idle_no_pending, clk, rst_n, plan_r == PLAN_IDLE, !pending_r)

endmodule
